### rtl/scl_pkg.sv
`timescale 1ns / 1ps

package scl_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_WAIT = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    CFG_OPEN_DELAY  = 2'd0,
    CFG_MOVE_DELAY  = 2'd1,
    CFG_START_FLOOR = 2'd2
  } cfg_idx_t;

  localparam int unsigned FLOOR_W = 4;
  localparam int unsigned DELAY_W = 16;

  localparam logic [DELAY_W-1:0] OPEN_DELAY_RST = 16'd3;
  localparam logic [DELAY_W-1:0] MOVE_DELAY_RST = 16'd5;
  localparam logic [DELAY_W-1:0] DWELL_MAX      = 16'hFFFF;

  // car state apart from the floor, whose width follows the floor count
  typedef struct packed {
    dir_t               dir;
    logic               open;
    logic               tgt_valid;
    logic [FLOOR_W-1:0] tgt_floor;
    logic [DELAY_W-1:0] dwell;
  } car_state_t;

  typedef struct packed {
    logic moved;
    logic opened;
    logic closed;
    logic rejected;
  } flags_t;

endpackage

### rtl/single_car_lift_controller.sv
`timescale 1ns / 1ps

// Lift car controller for one car. Every accepted item yields exactly one
// result, and a new item can be taken in every clock cycle while the output
// does not stall. An item sits in the input register, the car state is
// updated in a single combinational pass from there, and the result lands
// in the output register, which drives out_valid; the item moves on only
// while the output register is empty or out_ready is high. A stall on the
// output holds the input register, which then drops in_ready.
// Configuration writes are always accepted; start_floor moves the car at
// once to its low FLOOR_W bits, or to the top floor if at or above FLOORS.
module single_car_lift_controller
  import scl_pkg::*;
#(
  parameter int unsigned FLOORS = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [FLOOR_W-1:0] in_request_floor,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [FLOOR_W-1:0] out_car_floor,
  output logic [1:0]         out_car_direction,
  output logic               out_doors_open,
  output logic               out_target_valid,
  output logic [FLOOR_W-1:0] out_pending_floor,
  output logic               out_moved,
  output logic               out_opened,
  output logic               out_closed,
  output logic               out_rejected,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [DELAY_W-1:0] cfg_wdata
);

  localparam int unsigned FW = (FLOORS > 16) ? $clog2(FLOORS) : FLOOR_W;
  localparam logic [FW-1:0] LAST_FLOOR = FW'(FLOORS - 1);
  localparam logic [8:0]    FLOORS_W   = 9'(FLOORS);

  // input register
  logic               item_valid_r;
  func_t              item_func_r;
  logic [FLOOR_W-1:0] item_req_r;

  // configuration
  logic [DELAY_W-1:0] open_delay_r;
  logic [DELAY_W-1:0] move_delay_r;

  // car state
  logic [FW-1:0] floor_r;
  logic [FW-1:0] floor_nxt;
  car_state_t    state_r;
  car_state_t    state_nxt;
  flags_t        flags;

  // result register
  logic               res_valid_r;
  logic [FLOOR_W-1:0] res_floor_r;
  dir_t               res_dir_r;
  logic               res_open_r;
  logic               res_tgt_valid_r;
  logic [FLOOR_W-1:0] res_tgt_floor_r;
  flags_t             res_flags_r;

  logic advance;
  logic cfg_xfer;
  logic [FW-1:0] start_floor;

  assign advance   = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready  = !item_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  assign start_floor = ({5'b0, cfg_wdata[FLOOR_W-1:0]} >= FLOORS_W) ?
                       LAST_FLOOR : FW'(cfg_wdata[FLOOR_W-1:0]);

  scl_core #(
    .FLOORS (FLOORS),
    .FW     (FW)
  ) u_core (
    .func          (item_func_r),
    .request_floor (item_req_r),
    .open_delay    (open_delay_r),
    .move_delay    (move_delay_r),
    .floor_cur     (floor_r),
    .state_cur     (state_r),
    .floor_nxt     (floor_nxt),
    .state_nxt     (state_nxt),
    .flags         (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_func_r <= func_t'(in_func);
      item_req_r  <= in_request_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_delay_r <= OPEN_DELAY_RST;
      move_delay_r <= MOVE_DELAY_RST;
      floor_r      <= '0;
      state_r      <= '{dir: DIR_NONE, open: 1'b0, tgt_valid: 1'b0,
                        tgt_floor: '0, dwell: '0};
    end else begin
      if (advance) begin
        floor_r <= floor_nxt;
        state_r <= state_nxt;
      end
      if (cfg_xfer) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OPEN_DELAY:  open_delay_r <= cfg_wdata;
          CFG_MOVE_DELAY:  move_delay_r <= cfg_wdata;
          CFG_START_FLOOR: floor_r      <= start_floor;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_floor_r     <= floor_nxt[FLOOR_W-1:0];
      res_dir_r       <= state_nxt.dir;
      res_open_r      <= state_nxt.open;
      res_tgt_valid_r <= state_nxt.tgt_valid;
      res_tgt_floor_r <= state_nxt.tgt_valid ? state_nxt.tgt_floor : '0;
      res_flags_r     <= flags;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_car_floor     = res_floor_r;
  assign out_car_direction = res_dir_r;
  assign out_doors_open    = res_open_r;
  assign out_target_valid  = res_tgt_valid_r;
  assign out_pending_floor = res_tgt_floor_r;
  assign out_moved         = res_flags_r.moved;
  assign out_opened        = res_flags_r.opened;
  assign out_closed        = res_flags_r.closed;
  assign out_rejected      = res_flags_r.rejected;

endmodule

### rtl/scl_core.sv
`timescale 1ns / 1ps

module scl_core
  import scl_pkg::*;
#(
  parameter int unsigned FLOORS = 16,
  parameter int unsigned FW     = 4
) (
  input  func_t              func,
  input  logic [FLOOR_W-1:0] request_floor,
  input  logic [DELAY_W-1:0] open_delay,
  input  logic [DELAY_W-1:0] move_delay,
  input  logic [FW-1:0]      floor_cur,
  input  car_state_t         state_cur,
  output logic [FW-1:0]      floor_nxt,
  output car_state_t         state_nxt,
  output flags_t             flags
);

  localparam logic [FW-1:0] LAST_FLOOR = FW'(FLOORS - 1);
  localparam logic [8:0]    FLOORS_W   = 9'(FLOORS);

  logic [FW-1:0] req_ext;
  logic [FW-1:0] tgt_ext;
  logic [FW-1:0] f;
  car_state_t    s;
  flags_t        fl;

  assign req_ext = FW'(request_floor);
  assign tgt_ext = FW'(state_cur.tgt_floor);

  always_comb begin
    s  = state_cur;
    f  = floor_cur;
    fl = '0;
    case (func)
      FUNC_TICK: begin
        if ((s.open || s.dir != DIR_NONE) && s.dwell != DWELL_MAX) begin
          s.dwell = s.dwell + 1'b1;
        end
        if (s.open) begin
          if (s.dwell >= open_delay) begin
            s.dwell   = '0;
            s.open    = 1'b0;
            fl.closed = 1'b1;
            if (s.tgt_valid) begin
              if (tgt_ext > f) begin
                s.dir = DIR_UP;
              end else if (tgt_ext < f) begin
                s.dir = DIR_DOWN;
              end
            end
          end
        end else if (s.dir == DIR_NONE || s.dwell >= move_delay) begin
          s.dwell = '0;
          if (s.dir == DIR_UP && f < LAST_FLOOR) begin
            f        = f + 1'b1;
            fl.moved = 1'b1;
          end else if (s.dir == DIR_DOWN && f != '0) begin
            f        = f - 1'b1;
            fl.moved = 1'b1;
          end
          if (s.tgt_valid && f == tgt_ext) begin
            s.dir       = DIR_NONE;
            fl.opened   = ~s.open;
            s.open      = 1'b1;
            s.tgt_valid = 1'b0;
            s.tgt_floor = '0;
          end
        end
      end
      FUNC_SET: begin
        if ({5'b0, request_floor} >= FLOORS_W) begin
          fl.rejected = 1'b1;
        end else if (req_ext == f) begin
          if (s.dir != DIR_NONE) begin
            fl.rejected = 1'b1;
          end else begin
            fl.opened = ~s.open;
            s.open    = 1'b1;
          end
        end else if (req_ext > f) begin
          if (s.dir == DIR_DOWN) begin
            fl.rejected = 1'b1;
          end else begin
            if (!s.open) begin
              s.dir = DIR_UP;
            end
            s.tgt_valid = 1'b1;
            s.tgt_floor = request_floor;
          end
        end else begin
          if (s.dir == DIR_UP) begin
            fl.rejected = 1'b1;
          end else begin
            if (!s.open) begin
              s.dir = DIR_DOWN;
            end
            s.tgt_valid = 1'b1;
            s.tgt_floor = request_floor;
          end
        end
      end
      FUNC_WAIT: begin
        s.dwell = '0;
      end
      default: begin
      end
    endcase
    floor_nxt = f;
    state_nxt = s;
    flags     = fl;
  end

endmodule

### tb/lift_car_checker.sv
`timescale 1ns / 1ps

module lift_car_checker
  import scl_pkg::*;
#(
  parameter int unsigned FLOORS = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [FLOOR_W-1:0] in_request_floor,

  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [FLOOR_W-1:0] out_car_floor,
  input  logic [1:0]         out_car_direction,
  input  logic               out_doors_open,
  input  logic               out_target_valid,
  input  logic [FLOOR_W-1:0] out_pending_floor,
  input  logic               out_moved,
  input  logic               out_opened,
  input  logic               out_closed,
  input  logic               out_rejected,

  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [DELAY_W-1:0] cfg_wdata,

  output int                 fail_count,
  output int                 pending,
  output int                 n_results,
  output int                 n_steps,
  output int                 n_openings,
  output int                 n_refused
);

  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic [1:0]         dir;
    logic               open;
    logic               tgt_valid;
    logic [FLOOR_W-1:0] tgt_floor;
    logic               moved;
    logic               opened;
    logic               closed;
    logic               rejected;
  } car_status_t;

  logic [DELAY_W-1:0] open_delay;
  logic [DELAY_W-1:0] move_delay;
  logic [FLOOR_W-1:0] floor_q;
  car_state_t         car;
  car_status_t        expected_status_q[$];

  function automatic logic [FLOOR_W-1:0] clamp_floor(logic [FLOOR_W-1:0] f);
    return (int'(f) >= FLOORS) ? FLOOR_W'(FLOORS - 1) : f;
  endfunction

  function automatic void set_heading();
    if (car.tgt_valid) begin
      if (car.tgt_floor > floor_q) car.dir = DIR_UP;
      else if (car.tgt_floor < floor_q) car.dir = DIR_DOWN;
    end
  endfunction

  // advances the car state by one transfer and returns the status it reports
  function automatic car_status_t step_car(func_t op, logic [FLOOR_W-1:0] req);
    car_status_t s;
    s = '0;
    case (op)
      FUNC_TICK: begin
        if ((car.open || car.dir != DIR_NONE) && car.dwell != DWELL_MAX)
          car.dwell = car.dwell + 1'b1;
        if (car.open) begin
          if (car.dwell >= open_delay) begin
            car.dwell = '0;
            car.open  = 1'b0;
            s.closed  = 1'b1;
            set_heading();
          end
        end else if (car.dir == DIR_NONE || car.dwell >= move_delay) begin
          car.dwell = '0;
          if (car.dir == DIR_UP && int'(floor_q) + 1 < FLOORS) begin
            floor_q = floor_q + 1'b1;
            s.moved = 1'b1;
          end else if (car.dir == DIR_DOWN && floor_q != '0) begin
            floor_q = floor_q - 1'b1;
            s.moved = 1'b1;
          end
          if (car.tgt_valid && floor_q == car.tgt_floor) begin
            car.dir       = DIR_NONE;
            s.opened      = !car.open;
            car.open      = 1'b1;
            car.tgt_valid = 1'b0;
            car.tgt_floor = '0;
          end
        end
      end
      FUNC_SET: begin
        if (int'(req) >= FLOORS) begin
          s.rejected = 1'b1;
        end else if (req == floor_q) begin
          if (car.dir != DIR_NONE) begin
            s.rejected = 1'b1;
          end else begin
            s.opened = !car.open;
            car.open = 1'b1;
          end
        end else if (req > floor_q) begin
          if (car.dir == DIR_DOWN) begin
            s.rejected = 1'b1;
          end else begin
            if (!car.open) car.dir = DIR_UP;
            car.tgt_valid = 1'b1;
            car.tgt_floor = req;
          end
        end else begin
          if (car.dir == DIR_UP) begin
            s.rejected = 1'b1;
          end else begin
            if (!car.open) car.dir = DIR_DOWN;
            car.tgt_valid = 1'b1;
            car.tgt_floor = req;
          end
        end
      end
      FUNC_WAIT: car.dwell = '0;
      default: ;
    endcase
    s.floor     = floor_q;
    s.dir       = car.dir;
    s.open      = car.open;
    s.tgt_valid = car.tgt_valid;
    s.tgt_floor = car.tgt_valid ? car.tgt_floor : '0;
    return s;
  endfunction

  task automatic check_field(string name, logic [FLOOR_W-1:0] want,
                             logic [FLOOR_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    car_status_t want;
    if (!rst_n) begin
      open_delay = OPEN_DELAY_RST;
      move_delay = MOVE_DELAY_RST;
      floor_q    = clamp_floor('0);
      car        = '{dir: DIR_NONE, open: 1'b0, tgt_valid: 1'b0, tgt_floor: '0, dwell: '0};
      fail_count = 0;
      n_results  = 0;
      n_steps    = 0;
      n_openings = 0;
      n_refused  = 0;
      expected_status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OPEN_DELAY:  open_delay = cfg_wdata;
          CFG_MOVE_DELAY:  move_delay = cfg_wdata;
          CFG_START_FLOOR: floor_q = clamp_floor(cfg_wdata[FLOOR_W-1:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: status transfer with nothing outstanding (floor %0d)",
                     $time, out_car_floor);
        end else begin
          want = expected_status_q.pop_front();
          n_results++;
          n_steps    += int'(want.moved);
          n_openings += int'(want.opened);
          n_refused  += int'(want.rejected);
          check_field("car_floor", want.floor, out_car_floor);
          check_field("car_direction", FLOOR_W'(want.dir), FLOOR_W'(out_car_direction));
          check_field("doors_open", FLOOR_W'(want.open), FLOOR_W'(out_doors_open));
          check_field("target_valid", FLOOR_W'(want.tgt_valid),
                      FLOOR_W'(out_target_valid));
          check_field("pending_floor", want.tgt_floor, out_pending_floor);
          check_field("moved", FLOOR_W'(want.moved), FLOOR_W'(out_moved));
          check_field("opened", FLOOR_W'(want.opened), FLOOR_W'(out_opened));
          check_field("closed", FLOOR_W'(want.closed), FLOOR_W'(out_closed));
          check_field("rejected", FLOOR_W'(want.rejected), FLOOR_W'(out_rejected));
        end
      end
      if (in_valid && in_ready)
        expected_status_q = {expected_status_q,
                             step_car(func_t'(in_func), in_request_floor)};
    end
    pending <= expected_status_q.size();
  end

endmodule

### tb/tb_single_car_lift_controller.sv
`timescale 1ns / 1ps

module tb_single_car_lift_controller
  import scl_pkg::*;
();

  localparam int unsigned LIFT_FLOORS  = 16;
  localparam int          CLK_HALF     = 5;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          TIMEOUT_NS   = 10_000_000;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [FLOOR_W-1:0] in_request_floor;
  logic               out_valid;
  logic               out_ready;
  logic [FLOOR_W-1:0] out_car_floor;
  logic [1:0]         out_car_direction;
  logic               out_doors_open;
  logic               out_target_valid;
  logic [FLOOR_W-1:0] out_pending_floor;
  logic               out_moved;
  logic               out_opened;
  logic               out_closed;
  logic               out_rejected;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [DELAY_W-1:0] cfg_wdata;

  logic steady;
  int   items_sent;
  int   fail_count;
  int   pending;
  int   n_results;
  int   n_steps;
  int   n_openings;
  int   n_refused;

  always #CLK_HALF clk = ~clk;

  single_car_lift_controller #(
    .FLOORS(LIFT_FLOORS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_request_floor (in_request_floor),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_car_floor    (out_car_floor),
    .out_car_direction(out_car_direction),
    .out_doors_open   (out_doors_open),
    .out_target_valid (out_target_valid),
    .out_pending_floor(out_pending_floor),
    .out_moved        (out_moved),
    .out_opened       (out_opened),
    .out_closed       (out_closed),
    .out_rejected     (out_rejected),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  lift_car_checker #(
    .FLOORS(LIFT_FLOORS)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_request_floor (in_request_floor),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_car_floor    (out_car_floor),
    .out_car_direction(out_car_direction),
    .out_doors_open   (out_doors_open),
    .out_target_valid (out_target_valid),
    .out_pending_floor(out_pending_floor),
    .out_moved        (out_moved),
    .out_opened       (out_opened),
    .out_closed       (out_closed),
    .out_rejected     (out_rejected),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending),
    .n_results        (n_results),
    .n_steps          (n_steps),
    .n_openings       (n_openings),
    .n_refused        (n_refused)
  );

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 11);

  task automatic send_item(func_t f, logic [FLOOR_W-1:0] req);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_request_floor <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (f != FUNC_NOP) items_sent++;
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_item(FUNC_TICK, FLOOR_W'($urandom));
  endtask

  // hold off until every status transfer is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DELAY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic setup_car(logic [DELAY_W-1:0] open_d, logic [DELAY_W-1:0] move_d,
                           logic [FLOOR_W-1:0] start);
    write_reg(CFG_OPEN_DELAY, open_d);
    write_reg(CFG_MOVE_DELAY, move_d);
    write_reg(CFG_START_FLOOR, {12'($urandom), start});
    cfg_valid <= 1'b0;
  endtask

  // mostly trips: a target followed by a run of ticks, with some noise mixed in
  task automatic random_traffic(int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 70) begin
        send_item(FUNC_SET, FLOOR_W'($urandom_range(15)));
        repeat ($urandom_range(25, 2)) begin
          case ($urandom_range(19))
            0: send_item(FUNC_WAIT, FLOOR_W'($urandom));
            1: send_item(FUNC_SET, FLOOR_W'($urandom));
            2: send_item(FUNC_NOP, FLOOR_W'($urandom));
            default: send_item(FUNC_TICK, FLOOR_W'($urandom));
          endcase
        end
      end else begin
        case ($urandom_range(3))
          0: send_item(FUNC_TICK, FLOOR_W'($urandom));
          1: send_item(FUNC_SET, FLOOR_W'($urandom));
          2: send_item(FUNC_WAIT, FLOOR_W'($urandom));
          default: send_item(FUNC_NOP, FLOOR_W'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d status transfers outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = FUNC_NOP;
    in_request_floor = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_OPEN_DELAY;
    cfg_wdata        = '0;
    steady           = 1'b0;
    items_sent       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset delays, car at floor 0
    send_item(FUNC_NOP, 4'd15);
    send_item(FUNC_TICK, 4'd0);
    send_item(FUNC_SET, 4'd0);
    send_item(FUNC_SET, 4'd0);
    run_ticks(2);
    send_item(FUNC_WAIT, 4'd9);
    run_ticks(3);
    send_item(FUNC_SET, 4'd2);
    send_item(FUNC_SET, 4'd0);
    run_ticks(5);
    send_item(FUNC_SET, 4'd0);
    run_ticks(5);
    send_item(FUNC_SET, 4'd0);
    run_ticks(3);
    send_item(FUNC_SET, 4'd15);
    settle();

    setup_car(16'd0, 16'd0, 4'd15);
    random_traffic(200);
    settle();

    steady <= 1'b1;
    write_reg(CFG_UNUSED, 16'($urandom));
    setup_car(16'd2, 16'd3, 4'd0);
    random_traffic(80);
    steady <= 1'b0;
    random_traffic(80);
    settle();
    random_traffic(90);
    settle();

    // longest open delay: doors stay open through a short run of ticks
    setup_car(16'hFFFF, 16'd1, 4'd8);
    send_item(FUNC_SET, 4'd8);
    send_item(FUNC_SET, 4'd3);
    run_ticks(12);
    settle();

    setup_car(16'd0, 16'hFFFF, FLOOR_W'($urandom));
    random_traffic(40);
    settle();

    setup_car(16'd1, 16'd2, FLOOR_W'($urandom));
    random_traffic(160);
    settle();

    $display("Checked %0d car status transfers over six delay and start floor settings,",
             n_results);
    $display("  with %0d floor steps, %0d door openings and %0d refused targets.",
             n_steps, n_openings, n_refused);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
